### rtl/min_priority_queue_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the minimum priority queue
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_CORE_MACROS_SVH
`define MIN_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define MPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define MPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// Minimum priority queue package
// Operation and status codes, cell control bundle and default sizes.
// ----------------------------------------------------------------------------
package mpq_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned CAPACITY_DEFAULT    = 16;
  localparam int unsigned VALUE_WIDTH_DEFAULT = 32;

  // Fixed widths of the stream fields.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned PRIO_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned TOTAL_W  = 5;

  // Operation codes carried on s_tuser.
  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_FIND = 2'd2
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // insert the request item at its sorted place
    logic shl;  // shift every entry one cell towards the head
  } cell_ctl_t;

endpackage

### rtl/mpq_cell.sv
// ----------------------------------------------------------------------------
// Priority queue cell
// One slot of the sorted chain: holds a value and its priority and takes
// data from its left or right neighbour or from the request.
// ----------------------------------------------------------------------------
module mpq_cell #(
  parameter int unsigned VALUE_WIDTH = mpq_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  mpq_pkg::cell_ctl_t                ctl,
  input  logic [VALUE_WIDTH-1:0]            item_value,
  input  logic signed [mpq_pkg::PRIO_W-1:0] item_prio,
  input  logic                              occupied,
  input  logic [VALUE_WIDTH-1:0]            prev_value,
  input  logic signed [mpq_pkg::PRIO_W-1:0] prev_prio,
  input  logic                              prev_moves,
  input  logic [VALUE_WIDTH-1:0]            next_value,
  input  logic signed [mpq_pkg::PRIO_W-1:0] next_prio,
  output logic [VALUE_WIDTH-1:0]            slot_value,
  output logic signed [mpq_pkg::PRIO_W-1:0] slot_prio,
  output logic                              moves,
  output logic                              match
);

  // An occupied entry of strictly higher priority makes room for the new item,
  // so equal priorities keep their arrival order.
  assign moves = occupied && (slot_prio > item_prio);
  assign match = occupied && (slot_value == item_value);

  // Slot update: shift right on insert, shift left on removal.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (prev_moves) begin
        slot_value <= prev_value;
        slot_prio  <= prev_prio;
      end else if (moves || !occupied) begin
        slot_value <= item_value;
        slot_prio  <= item_prio;
      end
    end else if (ctl.shl) begin
      slot_value <= next_value;
      slot_prio  <= next_prio;
    end
  end

endmodule

### rtl/min_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Minimum priority queue core
// Bounded queue kept sorted in a chain of cells; the head leaves first.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake         Payload
// s_*      in   s_tvalid/s_tready s_tuser[1:0] op, s_tdata value and priority
// m_*      out  m_tvalid/m_tready m_tdata value, status, found, total, not empty
//
// Each request is applied to the cell chain in the cycle it is accepted and its
// result is registered, so one request can be taken every cycle.
// The figure is set by one step of the cell chain plus the match reduction.
// A waiting result stalls the input only while m_tready is low.
// Reset empties the queue at once; cell contents are left as they were.
//
module min_priority_queue_core #(
  parameter int unsigned CAPACITY    = mpq_pkg::CAPACITY_DEFAULT,
  parameter int unsigned VALUE_WIDTH = mpq_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // item_value [31:0], item_priority [47:32]
  input  logic [1:0]  s_tuser,   // op [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // out_value [31:0], status [33:32], found [34],
                                 // entry_total [39:35], not_empty [40]
);

`include "min_priority_queue_core_macros.svh"

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Request fields.
  logic                              accept;
  mpq_pkg::op_t                      op;
  logic [VALUE_WIDTH-1:0]            req_value;
  logic signed [mpq_pkg::PRIO_W-1:0] req_prio;

  // Queue state and cell chain.
  logic [CW-1:0]                     count;
  logic [CW-1:0]                     count_next;
  mpq_pkg::cell_ctl_t                ctl;
  logic [VALUE_WIDTH-1:0]            cell_value [CAPACITY];
  logic signed [mpq_pkg::PRIO_W-1:0] cell_prio  [CAPACITY];
  logic [CAPACITY-1:0]               cell_moves;
  logic [CAPACITY-1:0]               cell_match;
  logic [CAPACITY-1:0]               cell_occ;
  logic                              is_full;
  logic                              is_empty;

  // Result.
  logic [mpq_pkg::ITEM_W-1:0]        res_value;
  mpq_pkg::status_t                  res_status;
  logic                              res_found;
  logic [47:0]                       result_next;

  assign op        = mpq_pkg::op_t'(s_tuser);
  assign req_value = VALUE_WIDTH'(s_tdata[31:0]);
  assign req_prio  = s_tdata[47:32];
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign is_full   = (count == CW'(CAPACITY));
  assign is_empty  = (count == '0);

  // Decode the request into chain control, count update and result fields.
  always_comb begin
    ctl        = '0;
    count_next = count;
    res_value  = '0;
    res_status = mpq_pkg::ST_OK;
    res_found  = 1'b0;
    case (op)
      mpq_pkg::OP_ENQ: begin
        if (is_full) begin
          res_status = mpq_pkg::ST_FULL;
        end else begin
          ctl.ins    = accept;
          count_next = count + CW'(1);
        end
      end
      mpq_pkg::OP_DEQ: begin
        if (is_empty) begin
          res_status = mpq_pkg::ST_EMPTY;
        end else begin
          ctl.shl    = accept;
          count_next = count - CW'(1);
          res_value  = mpq_pkg::ITEM_W'(cell_value[0]);
        end
      end
      mpq_pkg::OP_FIND: begin
        res_found = |cell_match;
      end
      default: begin
      end
    endcase
  end

  // The chain of cells, each wired to both neighbours.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0]            prev_value;
    logic signed [mpq_pkg::PRIO_W-1:0] prev_prio;
    logic                              prev_moves;
    logic [VALUE_WIDTH-1:0]            next_value;
    logic signed [mpq_pkg::PRIO_W-1:0] next_prio;

    assign cell_occ[i] = (CW'(i) < count);

    if (i == 0) begin : g_head
      assign prev_value = '0;
      assign prev_prio  = '0;
      assign prev_moves = 1'b0;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_prio  = cell_prio[i-1];
      assign prev_moves = cell_moves[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_value = '0;
      assign next_prio  = '0;
    end else begin : g_inner
      assign next_value = cell_value[i+1];
      assign next_prio  = cell_prio[i+1];
    end

    mpq_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .item_value(req_value),
      .item_prio (req_prio),
      .occupied  (cell_occ[i]),
      .prev_value(prev_value),
      .prev_prio (prev_prio),
      .prev_moves(prev_moves),
      .next_value(next_value),
      .next_prio (next_prio),
      .slot_value(cell_value[i]),
      .slot_prio (cell_prio[i]),
      .moves     (cell_moves[i]),
      .match     (cell_match[i])
    );

    // Occupied neighbours must stay in non-decreasing priority order.
    if (i > 0) begin : g_order
      `MPQ_ASSERT_NOW(a_sorted, cell_occ[i], cell_prio[i-1] <= cell_prio[i],
                      "queue cells out of priority order")
    end
  end

  assign result_next = {7'd0, !(count_next == '0), mpq_pkg::TOTAL_W'(count_next),
                        res_found, res_status, res_value};

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Output register: holds one result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= result_next;
    end
  end

  `MPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(CAPACITY),
                  "entry count above capacity")
  `MPQ_ASSERT_NEXT(a_deq_count, accept && op == mpq_pkg::OP_DEQ && !is_empty,
                   count == $past(count) - CW'(1), "dequeue did not remove one entry")
  `MPQ_ASSERT_NEXT(a_full_drop, accept && op == mpq_pkg::OP_ENQ && is_full,
                   $stable(count) && m_tdata[33:32] == mpq_pkg::ST_FULL,
                   "enqueue on a full queue was not dropped")

endmodule

### sim/min_priority_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Result checker for the minimum priority queue
// Keeps its own sorted copy of the queue, works out the outcome of every
// accepted request and compares each result with the oldest outcome waiting.
// ----------------------------------------------------------------------------
module min_priority_queue_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // item_value [31:0], item_priority [47:32]
  input  logic [1:0]  s_tuser,   // op [1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // out_value [31:0], status [33:32], found [34],
                                 // entry_total [39:35], not_empty [40]
  output int          pending,
  output int          fail_count,
  output int          results_checked,
  output int          full_seen,
  output int          empty_seen,
  output int          hits_seen
);

  // Fields of one result as the block should report them.
  typedef struct {
    logic [31:0] out_value;
    logic [1:0]  status;
    logic        found;
    logic [4:0]  total;
    logic        not_empty;
  } outcome_t;

  // Mirror of the queue contents, head in slot 0.
  logic [31:0]        slot_val [CAPACITY];
  logic signed [15:0] slot_pri [CAPACITY];
  int unsigned        stored;

  outcome_t awaited_outcomes [$];

  // Apply one request to the mirror and return the result it should give.
  function automatic outcome_t next_outcome(input logic [1:0] op, input logic [31:0] val,
                                            input logic signed [15:0] pri);
    outcome_t    r;
    int unsigned pos;
    r.out_value = '0;
    r.status    = mpq_pkg::ST_OK;
    r.found     = 1'b0;
    case (op)
      mpq_pkg::OP_ENQ: begin
        if (stored >= CAPACITY) begin
          r.status = mpq_pkg::ST_FULL;
        end else begin
          // The new entry goes behind every entry of lower or equal priority.
          pos = stored;
          while (pos > 0 && slot_pri[pos-1] > pri) begin
            slot_val[pos] = slot_val[pos-1];
            slot_pri[pos] = slot_pri[pos-1];
            pos--;
          end
          slot_val[pos] = val;
          slot_pri[pos] = pri;
          stored++;
        end
      end
      mpq_pkg::OP_DEQ: begin
        if (stored == 0) begin
          r.status = mpq_pkg::ST_EMPTY;
        end else begin
          r.out_value = slot_val[0];
          for (int i = 1; i < stored; i++) begin
            slot_val[i-1] = slot_val[i];
            slot_pri[i-1] = slot_pri[i];
          end
          stored--;
        end
      end
      mpq_pkg::OP_FIND: begin
        for (int i = 0; i < stored; i++) begin
          if (slot_val[i] == val) r.found = 1'b1;
        end
      end
      default: ;  // the spare code leaves the queue alone
    endcase
    r.total     = stored[4:0];
    r.not_empty = (stored != 0);
    return r;
  endfunction

  // One line per mismatch; the count always advances.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Results are checked before the request of the same edge is applied, since a
  // result always belongs to an earlier request.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      stored = 0;
      awaited_outcomes.delete();
      fail_count      = 0;
      results_checked = 0;
      full_seen       = 0;
      empty_seen      = 0;
      hits_seen       = 0;
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch("unrequested result", m_tdata[31:0], '0);
        end else begin
          want = awaited_outcomes.pop_front();
          results_checked++;
          if (m_tdata[31:0] !== want.out_value)
            report_mismatch("out_value", m_tdata[31:0], want.out_value);
          if (m_tdata[33:32] !== want.status)
            report_mismatch("status", m_tdata[33:32], want.status);
          if (m_tdata[34] !== want.found)
            report_mismatch("found", m_tdata[34], want.found);
          if (m_tdata[39:35] !== want.total)
            report_mismatch("entry_total", m_tdata[39:35], want.total);
          if (m_tdata[40] !== want.not_empty)
            report_mismatch("not_empty", m_tdata[40], want.not_empty);
          if (want.status == mpq_pkg::ST_FULL) full_seen++;
          if (want.status == mpq_pkg::ST_EMPTY) empty_seen++;
          if (want.found) hits_seen++;
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_outcomes.push_back(next_outcome(s_tuser, s_tdata[31:0], s_tdata[47:32]));
      end
      pending <= awaited_outcomes.size();
    end
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the minimum priority queue core
// Drives directed and random enqueue, dequeue, find and spare-code requests under
// three idling mixes and two long output stalls; the checker compares every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] OP_NOP   = 2'd3;  // spare operation code
  localparam int CAPACITY        = 16;
  localparam int ITEMS_PER_PHASE = 460;
  localparam int STALL_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int DRAIN_CYCLES    = 8;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [47:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [47:0] m_tdata;

  int pending, fail_count, results_checked, full_seen, empty_seen, hits_seen;
  int send_idle    = 0;
  int recv_idle    = 0;
  int hold_asked   = 0;
  int hold_done    = 0;
  int quiet_cycles = 0;
  int sent_enq = 0, sent_deq = 0, sent_find = 0, sent_nop = 0;

  // Recently enqueued values, so that finds often hit.
  logic [31:0] recent_vals [8] = '{default: '0};
  int          recent_slot = 0;

  min_priority_queue_core #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (32)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  min_priority_queue_checker #(
    .CAPACITY (CAPACITY)
  ) queue_watch (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .pending         (pending),
    .fail_count      (fail_count),
    .results_checked (results_checked),
    .full_seen       (full_seen),
    .empty_seen      (empty_seen),
    .hits_seen       (hits_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one request after a random gap and wait until it is accepted.
  task automatic send_request(input logic [1:0] op, input logic [31:0] val,
                              input logic [15:0] pri);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pri, val};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (op)
      mpq_pkg::OP_ENQ: begin
        sent_enq++;
        recent_vals[recent_slot] = val;
        recent_slot = (recent_slot + 1) % 8;
      end
      mpq_pkg::OP_DEQ:  sent_deq++;
      mpq_pkg::OP_FIND: sent_find++;
      default: sent_nop++;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(7);
      2: return recent_vals[$urandom_range(7)];
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // Priorities lean towards small sets and the extremes so that ties are common.
  function automatic logic [15:0] pick_priority();
    case ($urandom_range(3))
      0: return 16'($urandom());
      1: return 16'(($urandom_range(4) - 2) * 256);
      2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom_range(15));
    endcase
  endfunction

  function automatic logic [1:0] pick_op(input int enq_pct);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 2) return OP_NOP;
    if (r < 17) return mpq_pkg::OP_FIND;
    if ($urandom_range(99) < enq_pct) return mpq_pkg::OP_ENQ;
    return mpq_pkg::OP_DEQ;
  endfunction

  // Receiver: random back-pressure, or a long hold when one is asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_done != hold_asked) begin
        m_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        hold_done = hold_asked;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Count cycles in which neither channel moves a request or a result.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    logic [1:0] op;
    int         enq_pct;
    int         real_sent;
    int         chunk;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty and full errors, extremes and ties at both ends.
    send_idle = 18;
    recv_idle = 50;
    send_request(mpq_pkg::OP_DEQ, 32'h0, 16'h0);
    send_request(mpq_pkg::OP_FIND, 32'h0, 16'h0);
    send_request(OP_NOP, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(mpq_pkg::OP_ENQ, 32'h7FFF_FFFF, 16'h7FFF);
    send_request(mpq_pkg::OP_ENQ, 32'h8000_0000, 16'h8000);
    send_request(mpq_pkg::OP_ENQ, 32'h0000_0000, 16'h7FFF);
    send_request(mpq_pkg::OP_ENQ, 32'hFFFF_FFFF, 16'h8000);
    send_request(mpq_pkg::OP_ENQ, 32'h0000_0005, 16'h0000);
    send_request(mpq_pkg::OP_FIND, 32'h8000_0000, 16'h1234);
    send_request(mpq_pkg::OP_FIND, 32'h1234_5678, 16'h0000);
    repeat (CAPACITY - 5) send_request(mpq_pkg::OP_ENQ, $urandom(), pick_priority());
    send_request(mpq_pkg::OP_ENQ, 32'hDEAD_BEEF, 16'h0000);
    send_request(mpq_pkg::OP_FIND, 32'h0000_0005, 16'h0000);
    send_request(mpq_pkg::OP_DEQ, 32'h0, 16'h0);

    // Random part in three idling mixes, in chunks that lean to fill, to drain or to neither.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 18; recv_idle = 50; end
        1: begin send_idle = 50; recv_idle = 18; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (phase != 1) hold_asked++;
      real_sent = 0;
      while (real_sent < ITEMS_PER_PHASE) begin
        case ($urandom_range(2))
          0: enq_pct = 25;
          1: enq_pct = 50;
          default: enq_pct = 80;
        endcase
        chunk = $urandom_range(10, 40);
        repeat (chunk) begin
          op = pick_op(enq_pct);
          send_request(op, pick_value(), pick_priority());
          if (op != OP_NOP) real_sent++;
        end
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d enqueue, %0d dequeue, %0d find and %0d spare-code requests",
             sent_enq, sent_deq, sent_find, sent_nop);
    $display("%0d results checked: %0d full rejections, %0d empty dequeues, %0d find hits",
             results_checked, full_seen, empty_seen, hits_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### min_priority_queue_core.f
+incdir+rtl
rtl/mpq_pkg.sv
rtl/mpq_cell.sv
rtl/min_priority_queue_core.sv
sim/min_priority_queue_checker.sv
sim/testbench.sv
